### rtl/bsed_pkg.sv
package bsed_pkg;

   typedef enum logic [1:0] {
      MODE_TEXT = 2'd0,
      MODE_ESC  = 2'd1,
      MODE_HEX  = 2'd2,
      MODE_OCT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_BAD_ESC = 2'd1,
      STATUS_BS_END  = 2'd2
   } status_type;

   localparam int ACC_WIDTH = 12;
   localparam int CNT_WIDTH = 3;

   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_X         = 8'h78;
   localparam logic [7:0] BYTE_MAX       = 8'hFF;

   typedef struct packed {
      logic [7:0] data;
      status_type status;
      logic       last;
   } result_type;

   typedef struct packed {
      logic       hit;
      logic [7:0] value;
   } esc_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] value;
   } hex_type;

   function automatic esc_type named_escape(input logic [7:0] c);
      esc_type r;
      r.hit = 1'b1;
      case (c)
         8'h5C:   r.value = 8'h5C;
         8'h27:   r.value = 8'h27;
         8'h22:   r.value = 8'h22;
         8'h61:   r.value = 8'h07;
         8'h62:   r.value = 8'h08;
         8'h65:   r.value = 8'h1B;
         8'h66:   r.value = 8'h0C;
         8'h6E:   r.value = 8'h0A;
         8'h72:   r.value = 8'h0D;
         8'h74:   r.value = 8'h09;
         8'h76:   r.value = 8'h0B;
         default: begin
            r.hit   = 1'b0;
            r.value = 8'h00;
         end
      endcase
      return r;
   endfunction

   function automatic hex_type hex_digit(input logic [7:0] c);
      hex_type r;
      r.hit   = 1'b1;
      r.value = 4'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r.value = 4'(c - 8'h30);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r.value = 4'(c - 8'h37);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r.value = 4'(c - 8'h57);
      end else begin
         r.hit = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [7:0] octal_sat(input logic [ACC_WIDTH-1:0] acc);
      return (acc > ACC_WIDTH'(BYTE_MAX)) ? BYTE_MAX : acc[7:0];
   endfunction

endpackage

### rtl/backslash_escape_decoder_unit.sv
// Channel  Dir  Handshake            Payload
// req      in   req_valid/req_stall  req_in_byte[7:0], req_in_last
// rsp      out  rsp_valid/rsp_stall  rsp_out_byte[7:0], rsp_status[1:0], rsp_out_last
//
// One byte per cycle while req_stall is low; each byte decodes combinationally into zero,
// one or two beats that go to a three-entry result queue. The queue drains one beat per
// cycle while rsp_stall is low.
// req_stall rises when the queue cannot take two more beats.
// Reset is synchronous: text mode, queue empty.
module backslash_escape_decoder_unit
   import bsed_pkg::*;
#(
   parameter int OCTAL_DIGITS_MAX = 4,
   parameter int HEX_DIGITS_MAX   = 2
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status,
   output logic       rsp_out_last
);

   mode_type               mode_ff, mode_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [ACC_WIDTH-1:0]   acc_ff, acc_in;
   result_type             q_ff [0:2];
   result_type             q_in [0:2];
   logic [1:0]             count_ff, count_in;

   logic                   accept, pop;
   logic [1:0]             base;
   logic [1:0]             n_res;
   result_type             res0, res1, text_res;
   logic                   text_is_esc;
   esc_type                esc;
   hex_type                hx;
   logic                   is_oct;
   logic [CNT_WIDTH-1:0]   cnt_inc;
   logic [ACC_WIDTH-1:0]   hex_acc, oct_acc, oct_first;
   logic                   hex_done, oct_done, oct_first_done;

   assign pop       = rsp_valid && !rsp_stall;
   assign req_stall = (count_ff == 2'd3) || ((count_ff == 2'd2) && !pop);
   assign accept    = req_valid && !req_stall;

   assign esc       = named_escape(req_in_byte);
   assign hx        = hex_digit(req_in_byte);
   assign is_oct    = (req_in_byte >= 8'h30) && (req_in_byte <= 8'h37);
   assign cnt_inc   = cnt_ff + CNT_WIDTH'(1);
   assign hex_acc   = {acc_ff[ACC_WIDTH-5:0], hx.value};
   assign oct_acc   = {acc_ff[ACC_WIDTH-4:0], req_in_byte[2:0]};
   assign oct_first = {{(ACC_WIDTH-3){1'b0}}, req_in_byte[2:0]};
   assign hex_done  = (cnt_inc >= CNT_WIDTH'(HEX_DIGITS_MAX)) || req_in_last;
   assign oct_done  = (cnt_inc >= CNT_WIDTH'(OCTAL_DIGITS_MAX)) || req_in_last;
   assign oct_first_done = (OCTAL_DIGITS_MAX <= 1) || req_in_last;

   assign text_is_esc = (req_in_byte == CHAR_BACKSLASH) && !req_in_last;
   always_comb begin
      if (req_in_byte == CHAR_BACKSLASH) begin
         text_res = '{data: 8'h00, status: STATUS_BS_END, last: 1'b1};
      end else begin
         text_res = '{data: req_in_byte, status: STATUS_OK, last: req_in_last};
      end
   end

   // next state
   always_comb begin
      mode_in = mode_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      unique case (mode_ff)
         MODE_TEXT: begin
            mode_in = text_is_esc ? MODE_ESC : MODE_TEXT;
         end
         MODE_ESC: begin
            mode_in = MODE_TEXT;
            if (!esc.hit && req_in_byte == CHAR_X) begin
               if (!req_in_last) begin
                  mode_in = MODE_HEX;
                  cnt_in  = '0;
                  acc_in  = '0;
               end
            end else if (!esc.hit && is_oct) begin
               acc_in  = oct_first;
               cnt_in  = CNT_WIDTH'(1);
               mode_in = oct_first_done ? MODE_TEXT : MODE_OCT;
            end
         end
         MODE_HEX: begin
            if (hx.hit) begin
               acc_in  = hex_acc;
               cnt_in  = cnt_inc;
               mode_in = hex_done ? MODE_TEXT : MODE_HEX;
            end else begin
               mode_in = text_is_esc ? MODE_ESC : MODE_TEXT;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               acc_in  = oct_acc;
               cnt_in  = cnt_inc;
               mode_in = oct_done ? MODE_TEXT : MODE_OCT;
            end else begin
               mode_in = text_is_esc ? MODE_ESC : MODE_TEXT;
            end
         end
         default: mode_in = MODE_TEXT;
      endcase
   end

   // results of this byte
   always_comb begin
      res0  = '{data: 8'h00, status: STATUS_OK, last: 1'b0};
      res1  = text_res;
      n_res = 2'd0;
      unique case (mode_ff)
         MODE_TEXT: begin
            res0  = text_res;
            n_res = text_is_esc ? 2'd0 : 2'd1;
         end
         MODE_ESC: begin
            if (esc.hit) begin
               res0  = '{data: esc.value, status: STATUS_OK, last: req_in_last};
               n_res = 2'd1;
            end else if (req_in_byte == CHAR_X) begin
               res0  = '{data: 8'h00, status: STATUS_BAD_ESC, last: 1'b1};
               n_res = req_in_last ? 2'd1 : 2'd0;
            end else if (is_oct) begin
               res0  = '{data: octal_sat(oct_first), status: STATUS_OK, last: req_in_last};
               n_res = oct_first_done ? 2'd1 : 2'd0;
            end else begin
               res0  = '{data: 8'h00, status: STATUS_BAD_ESC, last: req_in_last};
               n_res = 2'd1;
            end
         end
         MODE_HEX: begin
            if (hx.hit) begin
               res0  = '{data: hex_acc[7:0], status: STATUS_OK, last: req_in_last};
               n_res = hex_done ? 2'd1 : 2'd0;
            end else begin
               if (cnt_ff == '0) begin
                  res0 = '{data: 8'h00, status: STATUS_BAD_ESC, last: 1'b0};
               end else begin
                  res0 = '{data: acc_ff[7:0], status: STATUS_OK, last: 1'b0};
               end
               n_res = text_is_esc ? 2'd1 : 2'd2;
            end
         end
         MODE_OCT: begin
            if (is_oct) begin
               res0  = '{data: octal_sat(oct_acc), status: STATUS_OK, last: req_in_last};
               n_res = oct_done ? 2'd1 : 2'd0;
            end else begin
               res0  = '{data: octal_sat(acc_ff), status: STATUS_OK, last: 1'b0};
               n_res = text_is_esc ? 2'd1 : 2'd2;
            end
         end
         default: n_res = 2'd0;
      endcase
   end

   // result queue, head at entry 0
   assign base = count_ff - 2'(pop);

   always_comb begin
      q_in[0] = q_ff[0];
      q_in[1] = q_ff[1];
      q_in[2] = q_ff[2];
      if (pop) begin
         q_in[0] = q_ff[1];
         q_in[1] = q_ff[2];
      end
      if (accept && n_res != 2'd0) begin
         q_in[base] = res0;
      end
      if (accept && n_res == 2'd2) begin
         q_in[base + 2'd1] = res1;
      end
      count_in = base + (accept ? n_res : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_TEXT;
         cnt_ff   <= '0;
         acc_ff   <= '0;
         count_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
            cnt_ff  <= cnt_in;
            acc_ff  <= acc_in;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      q_ff[0] <= q_in[0];
      q_ff[1] <= q_in[1];
      q_ff[2] <= q_in[2];
   end

   assign rsp_valid    = (count_ff != 2'd0);
   assign rsp_out_byte = q_ff[0].data;
   assign rsp_status   = q_ff[0].status;
   assign rsp_out_last = q_ff[0].last;

   a_room_on_accept : assert property (@(posedge clock) disable iff (reset)
      accept |-> (base <= 2'd1))
      else $error("accepted beat without queue room");

   a_text_after_last : assert property (@(posedge clock) disable iff (reset)
      (accept && req_in_last) |=> (mode_ff == MODE_TEXT))
      else $error("escape pending after final byte");

   a_error_data_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_out_byte == 8'h00))
      else $error("error beat carries nonzero data");

endmodule
